// ===== sv/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Types and codes shared by the keyed record table: beat payloads, operation
// and status codes, controller states and the controller/datapath command
// and status bundles.
// ----------------------------------------------------------------------------
package krt_pkg;

	// fixed field widths
	localparam int unsigned KEY_W  = 8;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned USED_W = 5;

	// operation codes carried in the kind field
	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_READ = 2'd2,
		OP_LIST = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_SCORE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// request beat
	typedef struct packed {
		op_t               kind;
		logic [KEY_W-1:0]  key_id;
		logic [BYTE_W-1:0] year;
		logic [BYTE_W-1:0] subject_0;
		logic [BYTE_W-1:0] subject_1;
		logic [BYTE_W-1:0] subject_2;
		logic [BYTE_W-1:0] score_0;
		logic [BYTE_W-1:0] score_1;
		logic [BYTE_W-1:0] score_2;
	} req_t;

	// record body held in the payload memory
	typedef struct packed {
		logic [BYTE_W-1:0] year;
		logic [BYTE_W-1:0] subject_0;
		logic [BYTE_W-1:0] subject_1;
		logic [BYTE_W-1:0] subject_2;
		logic [BYTE_W-1:0] score_0;
		logic [BYTE_W-1:0] score_1;
		logic [BYTE_W-1:0] score_2;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

	// response beat
	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] out_year;
		logic [BYTE_W-1:0] out_subject_0;
		logic [BYTE_W-1:0] out_subject_1;
		logic [BYTE_W-1:0] out_subject_2;
		logic [BYTE_W-1:0] out_score_0;
		logic [BYTE_W-1:0] out_score_1;
		logic [BYTE_W-1:0] out_score_2;
		logic [USED_W-1:0] used_count;
		logic              full_res;
		logic [KEY_W-1:0]  listed_id;
		logic              last;
	} rsp_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA,
		S_LIST
	} state_t;

	// source of the record and listed id fields of a response
	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_REC,
		SEL_LIST
	} res_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     do_add;
		logic     do_del;
		logic     rd_issue;
		logic     list_step;
		logic     emit;
		res_sel_t sel;
		status_t  status;
		logic     last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  kind;
		logic found;
		logic full;
		logic empty;
		logic score_bad;
		logic list_end;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/krt_req_if.sv =====
// ----------------------------------------------------------------------------
// krt_req_if
// Request channel: valid/ready handshake carrying one operation per beat.
// ----------------------------------------------------------------------------
interface krt_req_if import krt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/krt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// krt_rsp_if
// Response channel: valid/ready handshake carrying one result per beat.
// ----------------------------------------------------------------------------
interface krt_rsp_if import krt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/krt_ram.sv =====
// ----------------------------------------------------------------------------
// krt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/krt_ctrl.sv =====
// ----------------------------------------------------------------------------
// krt_ctrl
// Operation sequencer: takes one request at a time, decides the outcome
// from datapath status and steps a list through the stored ids.
// ----------------------------------------------------------------------------
module krt_ctrl import krt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.sel       = SEL_NONE;
		cmd.status    = ST_OK;
		cmd.last      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.kind)
					OP_ADD: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							priority if (stat.full) begin
								cmd.status = ST_FULL;
							end else if (stat.found) begin
								cmd.status = ST_DUP;
							end else if (stat.score_bad) begin
								cmd.status = ST_SCORE;
							end else begin
								cmd.status = ST_OK;
								cmd.do_add = 1'b1;
							end
							state_d = S_IDLE;
						end
					end
					OP_DEL: begin
						if (stat.out_free) begin
							cmd.emit   = 1'b1;
							cmd.do_del = stat.found;
							cmd.status = stat.found ? ST_OK : ST_NOTFOUND;
							state_d    = S_IDLE;
						end
					end
					OP_READ: begin
						if (stat.found) begin
							cmd.rd_issue = 1'b1;
							state_d      = S_RDATA;
						end else if (stat.out_free) begin
							cmd.emit   = 1'b1;
							cmd.status = ST_NOTFOUND;
							state_d    = S_IDLE;
						end
					end
					OP_LIST: begin
						if (!stat.empty) begin
							state_d = S_LIST;
						end else if (stat.out_free) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_RDATA: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_REC;
					state_d  = S_IDLE;
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.sel       = SEL_LIST;
					cmd.last      = stat.list_end;
					cmd.list_step = 1'b1;
					if (stat.list_end) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/krt_dp.sv =====
// ----------------------------------------------------------------------------
// krt_dp
// Table datapath: ordered key row with parallel compare, slot row mapping
// each position to a payload memory slot, record count, max score register
// and the response output register.
// ----------------------------------------------------------------------------
module krt_dp import krt_pkg::*; #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	input  req_t              req_data,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp_data
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	req_t              op_q;
	logic [KEY_W-1:0]  key_q  [CAPACITY];
	logic [IDX_W-1:0]  slot_q [CAPACITY];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] max_score_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [CAPACITY-1:0] hit;
	logic [IDX_W-1:0]    hit_pos;
	logic [IDX_W-1:0]    hit_slot;
	logic [IDX_W-1:0]    add_slot;
	logic [KEY_W-1:0]    list_key;
	logic                out_free;
	rec_t                wr_rec;
	logic [REC_W-1:0]    rd_word;
	rec_t                rd_rec;
	rsp_t                res;

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req_data;
		end
	end

	// max score register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_score_q <= BYTE_W'(100);
		end else if (cfg_we) begin
			max_score_q <= cfg_wdata;
		end
	end

	// parallel key compare and one-hot selects over the rows
	always_comb begin
		hit      = '0;
		hit_pos  = '0;
		hit_slot = '0;
		add_slot = '0;
		list_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i] = (CNT_W'(i) < cnt_q) && (key_q[i] == op_q.key_id);
			if (hit[i]) begin
				hit_pos  = hit_pos | IDX_W'(i);
				hit_slot = hit_slot | slot_q[i];
			end
			if (cnt_q == CNT_W'(i)) begin
				add_slot = add_slot | slot_q[i];
			end
			if (idx_q == IDX_W'(i)) begin
				list_key = list_key | key_q[i];
			end
		end
	end

	assign out_free = !out_valid_q || rsp_ready;

	// status toward the controller
	always_comb begin
		stat.kind      = op_q.kind;
		stat.found     = |hit;
		stat.full      = (cnt_q == CNT_W'(CAPACITY));
		stat.empty     = (cnt_q == '0);
		stat.score_bad = (op_q.score_0 > max_score_q) || (op_q.score_1 > max_score_q) ||
			(op_q.score_2 > max_score_q);
		stat.list_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
		stat.out_free  = out_free;
	end

	// record count after the operation
	always_comb begin
		priority if (cmd.do_add) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.do_del) begin
			cnt_d = cnt_q - CNT_W'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// list position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
		end else if (cmd.list_step && !stat.list_end) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// key row: append at the tail, close the gap on delete
	always_ff @(posedge clk) begin
		if (cmd.do_add) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (cnt_q == CNT_W'(i)) begin
					key_q[i] <= op_q.key_id;
				end
			end
		end else if (cmd.do_del) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IDX_W'(i) >= hit_pos) begin
					key_q[i] <= key_q[i + 1];
				end
			end
		end
	end

	// slot row: a permutation of memory slots, free slots above the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_q[i] <= IDX_W'(i);
			end
		end else if (cmd.do_del) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IDX_W'(i) >= hit_pos) begin
					slot_q[i] <= slot_q[i + 1];
				end
			end
			slot_q[CAPACITY-1] <= hit_slot;
		end
	end

	// record body written on add
	always_comb begin
		wr_rec.year      = op_q.year;
		wr_rec.subject_0 = op_q.subject_0;
		wr_rec.subject_1 = op_q.subject_1;
		wr_rec.subject_2 = op_q.subject_2;
		wr_rec.score_0   = op_q.score_0;
		wr_rec.score_1   = op_q.score_1;
		wr_rec.score_2   = op_q.score_2;
	end

	krt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_rec_ram (
		.clk   (clk),
		.we    (cmd.do_add),
		.waddr (add_slot),
		.wdata (wr_rec),
		.re    (cmd.rd_issue),
		.raddr (hit_slot),
		.rdata (rd_word)
	);

	assign rd_rec = rec_t'(rd_word);

	// response assembly
	always_comb begin
		res            = '0;
		res.status     = cmd.status;
		res.used_count = USED_W'(cnt_d);
		res.full_res   = (cnt_d == CNT_W'(CAPACITY));
		res.last       = cmd.last;
		unique case (cmd.sel)
			SEL_REC: begin
				res.out_year      = rd_rec.year;
				res.out_subject_0 = rd_rec.subject_0;
				res.out_subject_1 = rd_rec.subject_1;
				res.out_subject_2 = rd_rec.subject_2;
				res.out_score_0   = rd_rec.score_0;
				res.out_score_1   = rd_rec.score_1;
				res.out_score_2   = rd_rec.score_2;
			end
			SEL_LIST: begin
				res.listed_id = list_key;
			end
			SEL_NONE: begin
				res.listed_id = '0;
			end
			default: begin
				res.listed_id = '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

// ===== sv/keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table
// Ordered table of up to CAPACITY records keyed by an 8-bit id, with add,
// delete, read and list operations.
// ----------------------------------------------------------------------------
// usage
// - req carries one operation per beat; rsp returns results, one beat for
//   add, delete and read, one beat per stored id for list (at least one),
//   with last set on the final beat of each operation
// - cfg_we/cfg_wdata set the largest score an add accepts; write only while
//   no operation is in flight
// - one operation at a time: req.ready is high only while the sequencer is
//   idle, which it is again the cycle after the final result is registered
// - add, delete and a read miss are decided by a single parallel compare against
//   all keys at once; a read hit adds a registered payload memory read; a list
//   steps through the stored ids, one id per cycle while the receiver keeps up,
//   and on an empty table gives its single result beat from the compare state
// - results sit in an output register; while rsp.ready is low the sequencer
//   holds, and the next request is taken while the last result still waits
// - reset empties the table and sets the score limit to 100; no clearing
//   pass over the payload memory is needed
// ----------------------------------------------------------------------------
module keyed_record_table import krt_pkg::*; #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	krt_req_if.sink           req,
	krt_rsp_if.source         rsp
);

	cmd_t  cmd;
	stat_t stat;

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	krt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req.data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

	// one operation in flight: no request taken right after another
	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while an operation is in flight");

	// any failure status ends its operation
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.status != ST_OK) |-> rsp.data.last)
		else $error("error status on a non-final beat");

	// a full result reports the capacity as count
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.full_res |-> rsp.data.used_count == USED_W'(CAPACITY))
		else $error("full flag disagrees with used count");

	// a full rejection only comes from a full table
	a_full_st: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.status == ST_FULL) |-> rsp.data.full_res)
		else $error("full status without full flag");

endmodule
